/* design/mtd_pkg.sv */
package mtd_pkg;

  // Field widths
  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned TASK_W  = 3;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned LIMIT_W = 20;
  localparam int unsigned DB_W    = 4;
  localparam int unsigned NKEYS   = 3;
  localparam int unsigned STATE_W = 3;
  localparam int unsigned CIDX_W  = 3;

  // Function codes of an input word
  localparam logic [FUNC_W-1:0] FN_POLL   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_START  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_FINISH = 3'd2;
  localparam logic [FUNC_W-1:0] FN_FAIL   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_MARK   = 3'd4;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_LIM_TWO   = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_LIM_THREE = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_LIM_FOUR  = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_LIM_FIVE  = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_DEBOUNCE  = 3'd4;

  // Configuration reset values
  localparam logic [LIMIT_W-1:0] LIM_TWO_RST   = 20'd20000;
  localparam logic [LIMIT_W-1:0] LIM_THREE_RST = 20'd5000;
  localparam logic [LIMIT_W-1:0] LIM_FOUR_RST  = 20'd8000;
  localparam logic [LIMIT_W-1:0] LIM_FIVE_RST  = 20'd30000;
  localparam logic [DB_W-1:0]    DB_RST        = 4'd10;

  // Key bit positions
  localparam int unsigned KEY_PREV = 0;
  localparam int unsigned KEY_NEXT = 1;
  localparam int unsigned KEY_CONF = 2;

  // Task range
  localparam logic [TASK_W-1:0] TASK_LO  = 3'd2;
  localparam logic [TASK_W-1:0] TASK_HI  = 3'd6;
  localparam logic [TASK_W-1:0] TASK_RST = 3'd2;

  // Reported run state codes
  localparam logic [STATE_W-1:0] RS_INIT    = 3'd0;
  localparam logic [STATE_W-1:0] RS_READY   = 3'd1;
  localparam logic [STATE_W-1:0] RS_RUN     = 3'd2;
  localparam logic [STATE_W-1:0] RS_DONE    = 3'd3;
  localparam logic [STATE_W-1:0] RS_FAULT   = 3'd4;
  localparam logic [STATE_W-1:0] RS_UNAVAIL = 3'd5;

  // Run phase, one-hot
  typedef enum logic [5:0] {
    PH_INIT    = 6'b000001,
    PH_READY   = 6'b000010,
    PH_RUN     = 6'b000100,
    PH_DONE    = 6'b001000,
    PH_FAULT   = 6'b010000,
    PH_UNAVAIL = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] lim_two;
    logic [LIMIT_W-1:0] lim_three;
    logic [LIMIT_W-1:0] lim_four;
    logic [LIMIT_W-1:0] lim_five_six;
    logic [DB_W-1:0]    db_samples;
  } cfg_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [TASK_W-1:0] task_id;
    logic [TIME_W-1:0] now_ms;
    logic [NKEYS-1:0]  key_levels;
    logic              start_permitted;
  } item_t;

  typedef struct packed {
    logic               accepted;
    logic [STATE_W-1:0] run_state;
    logic [TASK_W-1:0]  task_selected;
    logic [TIME_W-1:0]  run_time;
    logic [LIMIT_W-1:0] time_limit;
    logic               on_time;
    logic [NKEYS-1:0]   key_presses;
  } result_t;

  // Control from the run controller to the debouncers
  typedef struct packed {
    logic poll;
    logic load;
    logic commit;
  } key_ctl_t;

  function automatic logic [LIMIT_W-1:0] task_limit(input logic [TASK_W-1:0] t,
                                                    input cfg_t c);
    logic [LIMIT_W-1:0] l;
    l = '0;
    unique case (t)
      3'd2:    l = c.lim_two;
      3'd3:    l = c.lim_three;
      3'd4:    l = c.lim_four;
      3'd5:    l = c.lim_five_six;
      3'd6:    l = c.lim_five_six;
      default: l = '0;
    endcase
    return l;
  endfunction

  function automatic logic [STATE_W-1:0] phase_code(input phase_t p);
    logic [STATE_W-1:0] c;
    c = RS_INIT;
    unique case (p)
      PH_INIT:    c = RS_INIT;
      PH_READY:   c = RS_READY;
      PH_RUN:     c = RS_RUN;
      PH_DONE:    c = RS_DONE;
      PH_FAULT:   c = RS_FAULT;
      PH_UNAVAIL: c = RS_UNAVAIL;
      default:    c = RS_INIT;
    endcase
    return c;
  endfunction

endpackage

/* design/mtd_cfg.sv */
module mtd_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [mtd_pkg::CIDX_W-1:0]    wr_index,
  input  logic [mtd_pkg::LIMIT_W-1:0]   wr_data,
  output mtd_pkg::cfg_t                 cfg
);
  import mtd_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  // Register bank write decode; unknown indexes are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_LIM_TWO:   cfg_nxt.lim_two      = wr_data;
        CFG_LIM_THREE: cfg_nxt.lim_three    = wr_data;
        CFG_LIM_FOUR:  cfg_nxt.lim_four     = wr_data;
        CFG_LIM_FIVE:  cfg_nxt.lim_five_six = wr_data;
        CFG_DEBOUNCE:  cfg_nxt.db_samples   = wr_data[DB_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lim_two      <= LIM_TWO_RST;
      cfg_r.lim_three    <= LIM_THREE_RST;
      cfg_r.lim_four     <= LIM_FOUR_RST;
      cfg_r.lim_five_six <= LIM_FIVE_RST;
      cfg_r.db_samples   <= DB_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* design/mtd_debounce.sv */
module mtd_debounce (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mtd_pkg::key_ctl_t           ctl,
  input  logic [mtd_pkg::NKEYS-1:0]   key_levels,
  input  logic [mtd_pkg::DB_W-1:0]    db_samples,
  output logic [mtd_pkg::NKEYS-1:0]   presses
);
  import mtd_pkg::*;

  logic [NKEYS-1:0] stable_r, stable_nxt;
  logic [NKEYS-1:0] last_r, last_nxt;
  logic [DB_W-1:0]  cnt_r   [NKEYS];
  logic [DB_W-1:0]  cnt_nxt [NKEYS];
  logic [DB_W-1:0]  cnt_sat [NKEYS];
  logic [NKEYS-1:0] ev;

  // Per-key debounce: a repeated sample counts up to the threshold, then
  // becomes the stable level. A mark-ready word while initializing loads the raw levels directly.
  always_comb begin
    stable_nxt = stable_r;
    last_nxt   = last_r;
    ev         = '0;
    for (int i = 0; i < NKEYS; i++) begin
      cnt_nxt[i] = cnt_r[i];
      cnt_sat[i] = (cnt_r[i] < db_samples) ? cnt_r[i] + 4'd1 : cnt_r[i];
      if (ctl.load) begin
        stable_nxt[i] = key_levels[i];
        last_nxt[i]   = key_levels[i];
        cnt_nxt[i]    = '0;
      end else if (ctl.poll) begin
        if (key_levels[i] != last_r[i]) begin
          last_nxt[i] = key_levels[i];
          cnt_nxt[i]  = '0;
        end else begin
          cnt_nxt[i] = cnt_sat[i];
          if (cnt_sat[i] >= db_samples && key_levels[i] != stable_r[i]) begin
            stable_nxt[i] = key_levels[i];
            ev[i]         = key_levels[i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= '0;
      last_r   <= '0;
      for (int i = 0; i < NKEYS; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (ctl.commit) begin
      stable_r <= stable_nxt;
      last_r   <= last_nxt;
      for (int i = 0; i < NKEYS; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

  assign presses = ev;

  // A load leaves every key settled with a cleared count.
  a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit && ctl.load |=> stable_r == last_r && cnt_r[0] == '0
      && cnt_r[1] == '0 && cnt_r[2] == '0)
    else $error("debounce state not settled after load");

  // No press edge is reported outside a poll word.
  a_edge_only_poll: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.poll |-> presses == '0)
    else $error("press edge outside poll");

endmodule

/* design/mtd_ctrl.sv */
module mtd_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         fire,
  input  mtd_pkg::item_t               item,
  input  mtd_pkg::cfg_t                cfg,
  input  logic [mtd_pkg::NKEYS-1:0]    presses,
  output mtd_pkg::key_ctl_t            key_ctl,
  output mtd_pkg::result_t             res
);
  import mtd_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [TASK_W-1:0]   task_r, task_nxt;
  logic [TIME_W-1:0]   start_r, start_nxt;
  logic [TIME_W-1:0]   frozen_r, frozen_nxt;
  logic [TIME_W-1:0]   diff;
  logic [TIME_W-1:0]   elapsed;
  logic [LIMIT_W-1:0]  limit;
  logic                busy;
  logic                ok;
  logic                started;
  logic [TASK_W-1:0]   t;

  assign busy = (phase_r == PH_INIT) || (phase_r == PH_RUN);
  assign diff = item.now_ms - start_r;

  // Debouncer control for this word.
  assign key_ctl.poll   = (item.func == FN_POLL);
  assign key_ctl.load   = (item.func == FN_MARK) && (phase_r == PH_INIT);
  assign key_ctl.commit = fire;

  // Guarded phase transitions for one word.
  always_comb begin
    phase_nxt  = phase_r;
    task_nxt   = task_r;
    start_nxt  = start_r;
    frozen_nxt = frozen_r;
    ok         = 1'b0;
    started    = 1'b0;
    t          = task_r;
    unique case (item.func)
      FN_POLL: begin
        if (!busy) begin
          if (presses[KEY_PREV]) begin
            t          = (t <= TASK_LO) ? TASK_HI : t - 3'd1;
            phase_nxt  = PH_READY;
            frozen_nxt = '0;
          end
          if (presses[KEY_NEXT]) begin
            t          = (t >= TASK_HI) ? TASK_LO : t + 3'd1;
            phase_nxt  = PH_READY;
            frozen_nxt = '0;
          end
          task_nxt = t;
          if (presses[KEY_CONF] && task_limit(t, cfg) != '0) begin
            frozen_nxt = '0;
            if (item.start_permitted) begin
              start_nxt = item.now_ms;
              phase_nxt = PH_RUN;
              ok        = 1'b1;
              started   = 1'b1;
            end else begin
              phase_nxt = PH_UNAVAIL;
            end
          end
        end
      end
      FN_START: begin
        if (!busy && task_limit(item.task_id, cfg) != '0) begin
          task_nxt   = item.task_id;
          frozen_nxt = '0;
          if (item.start_permitted) begin
            start_nxt = item.now_ms;
            phase_nxt = PH_RUN;
            ok        = 1'b1;
            started   = 1'b1;
          end else begin
            phase_nxt = PH_UNAVAIL;
          end
        end
      end
      FN_FINISH, FN_FAIL: begin
        if (phase_r == PH_RUN && task_r == item.task_id) begin
          frozen_nxt = diff;
          phase_nxt  = (item.func == FN_FINISH) ? PH_DONE : PH_FAULT;
          ok         = 1'b1;
        end
      end
      FN_MARK: begin
        if (phase_r == PH_INIT) begin
          phase_nxt = PH_READY;
          ok        = 1'b1;
        end
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
  end

  // Snapshot after the update.
  always_comb begin
    if (phase_nxt == PH_RUN) begin
      elapsed = started ? '0 : diff;
    end else begin
      elapsed = frozen_nxt;
    end
    limit = task_limit(task_nxt, cfg);
    res.accepted      = ok;
    res.run_state     = phase_code(phase_nxt);
    res.task_selected = task_nxt;
    res.run_time      = elapsed;
    res.time_limit    = limit;
    res.on_time       = (phase_nxt == PH_DONE)
                        && (elapsed <= {{(TIME_W-LIMIT_W){1'b0}}, limit});
    res.key_presses   = presses;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_INIT;
      task_r   <= TASK_RST;
      start_r  <= '0;
      frozen_r <= '0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      task_r   <= task_nxt;
      start_r  <= start_nxt;
      frozen_r <= frozen_nxt;
    end
  end

  // A rejected mark-ready leaves the phase alone.
  a_mark_rejected: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.func == FN_MARK && phase_r != PH_INIT |=> phase_r == $past(phase_r))
    else $error("rejected mark-ready changed the phase");

  // An accepted start runs from the word's time.
  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.func == FN_START && ok |=> phase_r == PH_RUN
      && start_r == $past(item.now_ms))
    else $error("accepted start did not begin a run");

  // A run always belongs to a real task.
  a_run_task: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_RUN |-> task_r >= TASK_LO && task_r <= TASK_HI)
    else $error("running on a task outside the menu");

endmodule

/* design/menu_run_timer_with_debounce.sv */
// Channel  Handshake                 Payload
// in       in_valid / in_stall       func, task_id, now_ms, key_levels, start_permitted
// out      out_valid / out_stall     accepted, run_state, task_selected, run_time,
//                                    time_limit, on_time, key_presses
// cfg      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One word per cycle unless the result stalls; words pass the input and result registers.
// The work for a word is one pass of logic between the input register and the
// result register, set by the debounce compare, the menu step and the limit compare.
// Synchronous reset puts the timer in initializing with all keys released.
// A stalled result holds; the input stage stalls only while it is full behind it.
module menu_run_timer_with_debounce (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mtd_pkg::FUNC_W-1:0]    in_func,
  input  logic [mtd_pkg::TASK_W-1:0]    in_task_id,
  input  logic [mtd_pkg::TIME_W-1:0]    in_now_ms,
  input  logic [mtd_pkg::NKEYS-1:0]     in_key_levels,
  input  logic                          in_start_permitted,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_accepted,
  output logic [mtd_pkg::STATE_W-1:0]   out_run_state,
  output logic [mtd_pkg::TASK_W-1:0]    out_task_selected,
  output logic [mtd_pkg::TIME_W-1:0]    out_run_time,
  output logic [mtd_pkg::LIMIT_W-1:0]   out_time_limit,
  output logic                          out_on_time,
  output logic [mtd_pkg::NKEYS-1:0]     out_key_presses,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mtd_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [mtd_pkg::LIMIT_W-1:0]   cfg_data
);
  import mtd_pkg::*;

  logic      s1_valid_r, s1_valid_nxt;
  item_t     s1_item_r;
  item_t     in_item;
  logic      out_valid_r, out_valid_nxt;
  result_t   out_res_r;
  result_t   res;
  logic      out_hold;
  logic      fire;
  cfg_t      cfg;
  key_ctl_t  key_ctl;
  logic [NKEYS-1:0] presses;

  // Handshake between stages.
  assign out_hold  = out_valid_r && out_stall;
  assign fire      = s1_valid_r && !out_hold;
  assign in_stall  = s1_valid_r && out_hold;
  assign cfg_ready = 1'b1;

  assign in_item.func            = in_func;
  assign in_item.task_id         = in_task_id;
  assign in_item.now_ms          = in_now_ms;
  assign in_item.key_levels      = in_key_levels;
  assign in_item.start_permitted = in_start_permitted;

  assign s1_valid_nxt  = in_stall ? s1_valid_r : in_valid;
  assign out_valid_nxt = out_hold ? out_valid_r : s1_valid_r;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_item;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res;
    end
  end

  mtd_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  mtd_debounce u_debounce (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (key_ctl),
    .key_levels (s1_item_r.key_levels),
    .db_samples (cfg.db_samples),
    .presses    (presses)
  );

  mtd_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .item    (s1_item_r),
    .cfg     (cfg),
    .presses (presses),
    .key_ctl (key_ctl),
    .res     (res)
  );

  assign out_valid         = out_valid_r;
  assign out_accepted      = out_res_r.accepted;
  assign out_run_state     = out_res_r.run_state;
  assign out_task_selected = out_res_r.task_selected;
  assign out_run_time      = out_res_r.run_time;
  assign out_time_limit    = out_res_r.time_limit;
  assign out_on_time       = out_res_r.on_time;
  assign out_key_presses   = out_res_r.key_presses;

endmodule

/* test/stopwatch_check.sv */
`timescale 1ns / 1ps

module stopwatch_check (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [mtd_pkg::FUNC_W-1:0]   in_func,
  input  logic [mtd_pkg::TASK_W-1:0]   in_task_id,
  input  logic [mtd_pkg::TIME_W-1:0]   in_now_ms,
  input  logic [mtd_pkg::NKEYS-1:0]    in_key_levels,
  input  logic                         in_start_permitted,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic                         out_accepted,
  input  logic [mtd_pkg::STATE_W-1:0]  out_run_state,
  input  logic [mtd_pkg::TASK_W-1:0]   out_task_selected,
  input  logic [mtd_pkg::TIME_W-1:0]   out_run_time,
  input  logic [mtd_pkg::LIMIT_W-1:0]  out_time_limit,
  input  logic                         out_on_time,
  input  logic [mtd_pkg::NKEYS-1:0]    out_key_presses,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [mtd_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [mtd_pkg::LIMIT_W-1:0]  cfg_data,
  output int unsigned                  mismatch_count,
  output int unsigned                  waiting_count
);
  import mtd_pkg::*;

  // Shadow copy of the configuration registers.
  logic [LIMIT_W-1:0] lim_two_q;
  logic [LIMIT_W-1:0] lim_three_q;
  logic [LIMIT_W-1:0] lim_four_q;
  logic [LIMIT_W-1:0] lim_five_six_q;
  logic [DB_W-1:0]    db_need;

  // Shadow copy of the stopwatch and the key debouncers.
  logic [STATE_W-1:0] phase_q;
  logic [TASK_W-1:0]  sel_task;
  logic [TIME_W-1:0]  run_origin;
  logic [TIME_W-1:0]  held_elapsed;
  logic [NKEYS-1:0]   key_level_q;
  logic [NKEYS-1:0]   key_sample_q;
  logic [DB_W-1:0]    key_count_q [NKEYS];

  // Snapshots predicted for accepted words, oldest first.
  result_t snapshot_q [$];

  function automatic logic [LIMIT_W-1:0] limit_of(input logic [TASK_W-1:0] t);
    case (t)
      3'd2:       return lim_two_q;
      3'd3:       return lim_three_q;
      3'd4:       return lim_four_q;
      3'd5, 3'd6: return lim_five_six_q;
      default:    return '0;
    endcase
  endfunction

  // A start needs a nonzero limit and a timer that is neither initializing nor running.
  function automatic logic try_launch(input logic [TASK_W-1:0] t,
                                      input logic [TIME_W-1:0] now,
                                      input logic permit);
    if (limit_of(t) == '0 || phase_q == RS_INIT || phase_q == RS_RUN) return 1'b0;
    sel_task = t;
    held_elapsed = '0;
    if (!permit) begin
      phase_q = RS_UNAVAIL;
      return 1'b0;
    end
    run_origin = now;
    phase_q = RS_RUN;
    return 1'b1;
  endfunction

  // Finish or fail only stops a run of the same task.
  function automatic logic halt_run(input logic [TASK_W-1:0] t,
                                    input logic [TIME_W-1:0] now,
                                    input logic [STATE_W-1:0] ending);
    if (phase_q != RS_RUN || sel_task != t) return 1'b0;
    held_elapsed = now - run_origin;
    phase_q = ending;
    return 1'b1;
  endfunction

  function automatic void step_selection(input logic back);
    if (back) begin
      sel_task = (sel_task <= TASK_LO) ? TASK_HI : sel_task - 3'd1;
    end else begin
      sel_task = (sel_task >= TASK_HI) ? TASK_LO : sel_task + 3'd1;
    end
    held_elapsed = '0;
    phase_q = RS_READY;
  endfunction

  function automatic result_t predict_snapshot(input item_t w);
    result_t r;
    logic [NKEYS-1:0] presses;
    logic ok;
    presses = '0;
    ok = 1'b0;
    case (w.func)
      FN_POLL: begin
        // Debounce each key, then apply previous, next and confirm in that order.
        for (int k = 0; k < NKEYS; k++) begin
          if (w.key_levels[k] != key_sample_q[k]) begin
            key_sample_q[k] = w.key_levels[k];
            key_count_q[k] = '0;
          end else begin
            if (key_count_q[k] < db_need) key_count_q[k] = key_count_q[k] + 4'd1;
            if (key_count_q[k] >= db_need && w.key_levels[k] != key_level_q[k]) begin
              key_level_q[k] = w.key_levels[k];
              presses[k] = w.key_levels[k];
            end
          end
        end
        if (phase_q != RS_INIT && phase_q != RS_RUN) begin
          if (presses[KEY_PREV]) step_selection(1'b1);
          if (presses[KEY_NEXT]) step_selection(1'b0);
          if (presses[KEY_CONF]) ok = try_launch(sel_task, w.now_ms, w.start_permitted);
        end
      end
      FN_START:  ok = try_launch(w.task_id, w.now_ms, w.start_permitted);
      FN_FINISH: ok = halt_run(w.task_id, w.now_ms, RS_DONE);
      FN_FAIL:   ok = halt_run(w.task_id, w.now_ms, RS_FAULT);
      FN_MARK: begin
        // Leaving initializing resynchronizes the debouncers to the current levels.
        if (phase_q == RS_INIT) begin
          key_level_q = w.key_levels;
          key_sample_q = w.key_levels;
          for (int k = 0; k < NKEYS; k++) key_count_q[k] = '0;
          phase_q = RS_READY;
          ok = 1'b1;
        end
      end
      default: ;
    endcase

    r.accepted = ok;
    r.run_state = phase_q;
    r.task_selected = sel_task;
    r.run_time = (phase_q == RS_RUN) ? w.now_ms - run_origin : held_elapsed;
    r.time_limit = limit_of(sel_task);
    r.on_time = (phase_q == RS_DONE)
                && (r.run_time <= {{(TIME_W-LIMIT_W){1'b0}}, r.time_limit});
    r.key_presses = presses;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [TIME_W-1:0] want,
                               input logic [TIME_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Track configuration writes, predict on every accepted input word and
  // compare every accepted result word with the oldest prediction.
  always @(posedge clk) begin
    item_t   word;
    result_t want;
    if (!rst_n) begin
      lim_two_q = LIM_TWO_RST;
      lim_three_q = LIM_THREE_RST;
      lim_four_q = LIM_FOUR_RST;
      lim_five_six_q = LIM_FIVE_RST;
      db_need = DB_RST;
      phase_q = RS_INIT;
      sel_task = TASK_RST;
      run_origin = '0;
      held_elapsed = '0;
      key_level_q = '0;
      key_sample_q = '0;
      for (int k = 0; k < NKEYS; k++) key_count_q[k] = '0;
      snapshot_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LIM_TWO:   lim_two_q = cfg_data;
          CFG_LIM_THREE: lim_three_q = cfg_data;
          CFG_LIM_FOUR:  lim_four_q = cfg_data;
          CFG_LIM_FIVE:  lim_five_six_q = cfg_data;
          CFG_DEBOUNCE:  db_need = cfg_data[DB_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        word.func = in_func;
        word.task_id = in_task_id;
        word.now_ms = in_now_ms;
        word.key_levels = in_key_levels;
        word.start_permitted = in_start_permitted;
        snapshot_q.push_back(predict_snapshot(word));
      end
      if (out_valid && !out_stall) begin
        if (snapshot_q.size() == 0) begin
          $display("%0t: result word with no prediction waiting, expected none, actual %0h",
                   $time, out_run_time);
          mismatch_count++;
        end else begin
          want = snapshot_q.pop_front();
          compare_field("accepted", TIME_W'(want.accepted), TIME_W'(out_accepted));
          compare_field("run_state", TIME_W'(want.run_state), TIME_W'(out_run_state));
          compare_field("task_selected", TIME_W'(want.task_selected),
                        TIME_W'(out_task_selected));
          compare_field("run_time", want.run_time, out_run_time);
          compare_field("time_limit", TIME_W'(want.time_limit), TIME_W'(out_time_limit));
          compare_field("on_time", TIME_W'(want.on_time), TIME_W'(out_on_time));
          compare_field("key_presses", TIME_W'(want.key_presses), TIME_W'(out_key_presses));
        end
      end
    end
    waiting_count = snapshot_q.size();
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import mtd_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned PHASES = 6;
  localparam int unsigned WORDS_PER_PHASE = 318;
  localparam logic [CIDX_W-1:0] CFG_UNUSED = 3'd7;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [FUNC_W-1:0]   in_func = '0;
  logic [TASK_W-1:0]   in_task_id = '0;
  logic [TIME_W-1:0]   in_now_ms = '0;
  logic [NKEYS-1:0]    in_key_levels = '0;
  logic                in_start_permitted = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_accepted;
  logic [STATE_W-1:0]  out_run_state;
  logic [TASK_W-1:0]   out_task_selected;
  logic [TIME_W-1:0]   out_run_time;
  logic [LIMIT_W-1:0]  out_time_limit;
  logic                out_on_time;
  logic [NKEYS-1:0]    out_key_presses;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CIDX_W-1:0]   cfg_index = '0;
  logic [LIMIT_W-1:0]  cfg_data = '0;

  int unsigned mismatch_count;
  int unsigned waiting_count;

  // Idling controls; calm turns off all idling for the last part of the run.
  logic        calm = 1'b0;
  int unsigned stall_pct = 25;
  int unsigned gap_pct = 20;
  int unsigned stall_left = 0;

  // Stimulus-side bookkeeping: wall clock in ms and the last task named in a start command.
  logic [TIME_W-1:0] clock_ms;
  logic [TASK_W-1:0] last_task = TASK_LO;

  menu_run_timer_with_debounce dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_task_id         (in_task_id),
    .in_now_ms          (in_now_ms),
    .in_key_levels      (in_key_levels),
    .in_start_permitted (in_start_permitted),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_accepted       (out_accepted),
    .out_run_state      (out_run_state),
    .out_task_selected  (out_task_selected),
    .out_run_time       (out_run_time),
    .out_time_limit     (out_time_limit),
    .out_on_time        (out_on_time),
    .out_key_presses    (out_key_presses),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  stopwatch_check u_stopwatch_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_task_id         (in_task_id),
    .in_now_ms          (in_now_ms),
    .in_key_levels      (in_key_levels),
    .in_start_permitted (in_start_permitted),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_accepted       (out_accepted),
    .out_run_state      (out_run_state),
    .out_task_selected  (out_task_selected),
    .out_run_time       (out_run_time),
    .out_time_limit     (out_time_limit),
    .out_on_time        (out_on_time),
    .out_key_presses    (out_key_presses),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .mismatch_count     (mismatch_count),
    .waiting_count      (waiting_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Result side: stall in random bursts.
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      stall_left <= 0;
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(0, 8);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offer one word, after an optional gap, and hold it until it is taken.
  task automatic send_word(input logic [FUNC_W-1:0] f, input logic [TASK_W-1:0] t,
                           input logic [TIME_W-1:0] now, input logic [NKEYS-1:0] keys,
                           input logic permit);
    int unsigned gap;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_task_id <= t;
    in_now_ms <= now;
    in_key_levels <= keys;
    in_start_permitted <= permit;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  // Stop sending and wait until every predicted word has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [LIMIT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Time moves forward in small steps, with an occasional jump anywhere.
  function automatic logic [TIME_W-1:0] tick_clock();
    if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(0, 1500);
    return clock_ms;
  endfunction

  // Phase 1 uses the largest limits, phase 3 the smallest nonzero, others a mix.
  function automatic logic [LIMIT_W-1:0] phase_limit(input int unsigned p);
    logic [LIMIT_W-1:0] v;
    v = LIMIT_W'($urandom);
    if (p == 1) return '1;
    if (p == 3) return 20'd1;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 20'd1;
      2:       return '1;
      3:       return v;
      default: return LIMIT_W'($urandom_range(1, 4000));
    endcase
  endfunction

  // Mostly well-formed key holds and start/stop commands, with some noise.
  task automatic random_phase(input int unsigned quota, input int unsigned db,
                              input logic pause_midway);
    int unsigned done_words;
    int unsigned hold;
    logic [NKEYS-1:0] lvl;
    logic [TASK_W-1:0] t;
    done_words = 0;
    while (done_words < quota) begin
      if (pause_midway && done_words >= quota / 2) begin
        drain();
        pause_midway = 1'b0;
      end
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8: begin
          // Hold one level long enough to pass the debouncer, or bounce early.
          if ($urandom_range(0, 1) != 0) lvl = 3'b001 << $urandom_range(0, 2);
          else lvl = NKEYS'($urandom_range(0, 7));
          hold = db + 1 + $urandom_range(0, 2);
          if ($urandom_range(0, 6) == 0) hold = $urandom_range(1, db + 1);
          repeat (hold) begin
            send_word(FN_POLL, TASK_W'($urandom), tick_clock(), lvl,
                      $urandom_range(0, 9) != 0);
          end
          done_words += hold;
        end
        9, 10, 11, 12: begin
          t = ($urandom_range(0, 3) != 0) ? TASK_W'($urandom_range(2, 6))
                                          : TASK_W'($urandom_range(0, 7));
          last_task = t;
          send_word(FN_START, t, tick_clock(), NKEYS'($urandom), $urandom_range(0, 6) != 0);
          done_words++;
        end
        13, 14, 15, 16: begin
          t = ($urandom_range(0, 1) != 0) ? last_task : TASK_W'($urandom_range(0, 7));
          send_word(($urandom_range(0, 2) != 0) ? FN_FINISH : FN_FAIL, t, tick_clock(),
                    NKEYS'($urandom), 1'($urandom));
          done_words++;
        end
        default: begin
          send_word(FUNC_W'($urandom), TASK_W'($urandom), $urandom, NKEYS'($urandom),
                    1'($urandom));
          done_words++;
        end
      endcase
    end
  endtask

  initial begin
    int unsigned db;
    logic [LIMIT_W-1:0] db_word;
    clock_ms = $urandom;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values: eleven equal polls pass the default debouncer while initializing.
    repeat (11) send_word(FN_POLL, 3'd0, tick_clock(), 3'b111, 1'b1);
    send_word(FN_START, 3'd2, 32'd10, 3'd0, 1'b1);
    send_word(FN_FINISH, 3'd2, 32'd20, 3'd0, 1'b1);
    send_word(3'd7, 3'd2, 32'd30, 3'd0, 1'b1);
    send_word(FN_MARK, 3'd0, 32'd40, 3'b001, 1'b0);
    send_word(FN_MARK, 3'd0, 32'd50, 3'b110, 1'b1);
    // Starts: task out of range, start not permitted, wrapped run, start while running.
    send_word(FN_START, 3'd7, 32'd60, 3'd0, 1'b1);
    send_word(FN_START, 3'd3, 32'd70, 3'd0, 1'b0);
    send_word(FN_START, 3'd4, 32'hFFFF_FF00, 3'd0, 1'b1);
    send_word(FN_START, 3'd5, 32'hFFFF_FF10, 3'd0, 1'b1);
    send_word(FN_POLL, 3'd0, 32'hFFFF_FF20, 3'b000, 1'b1);
    send_word(FN_FINISH, 3'd4, 32'h0000_0200, 3'd0, 1'b1);
    // Fault with the largest elapsed time, then a finish past the limit.
    send_word(FN_START, 3'd6, 32'd0, 3'd0, 1'b1);
    send_word(FN_FAIL, 3'd6, 32'hFFFF_FFFF, 3'd0, 1'b1);
    send_word(FN_START, 3'd2, 32'd100, 3'd0, 1'b1);
    send_word(FN_FINISH, 3'd2, 32'd20101, 3'd0, 1'b1);

    drain();
    write_reg(CFG_LIM_THREE, '0);
    write_reg(CFG_DEBOUNCE, 20'd1);

    // Zero limit rejects a start; then the menu with a single-sample debouncer.
    send_word(FN_START, 3'd3, tick_clock(), 3'd0, 1'b1);
    send_word(FN_POLL, 3'd0, tick_clock(), 3'b000, 1'b1);
    repeat (2) send_word(FN_POLL, 3'd0, tick_clock(), 3'b011, 1'b1);
    repeat (2) send_word(FN_POLL, 3'd0, tick_clock(), 3'b100, 1'b0);
    repeat (2) send_word(FN_POLL, 3'd0, tick_clock(), 3'b000, 1'b1);
    repeat (2) send_word(FN_POLL, 3'd0, tick_clock(), 3'b100, 1'b1);
    // A press while running is reported but ignored.
    repeat (2) send_word(FN_POLL, 3'd0, tick_clock(), 3'b001, 1'b1);
    send_word(FN_FINISH, 3'd2, tick_clock(), 3'd0, 1'b1);

    for (int unsigned p = 0; p < PHASES; p++) begin
      drain();
      calm <= (p == PHASES - 1);
      stall_pct <= (p == 0) ? 0 : $urandom_range(10, 40);
      gap_pct = (p == 4) ? 0 : $urandom_range(10, 40);
      case (p)
        1:       db = 15;
        2:       db = 0;
        3:       db = 1;
        default: db = $urandom_range(1, 4);
      endcase
      db_word = LIMIT_W'($urandom);
      db_word[DB_W-1:0] = DB_W'(db);
      write_reg(CFG_LIM_TWO, phase_limit(p));
      write_reg(CFG_LIM_THREE, phase_limit(p));
      write_reg(CFG_LIM_FOUR, phase_limit(p));
      write_reg(CFG_LIM_FIVE, phase_limit(p));
      write_reg(CFG_DEBOUNCE, db_word);
      if (p == 0) write_reg(CFG_UNUSED, LIMIT_W'($urandom));
      random_phase(WORDS_PER_PHASE, db, p == 2);
    end

    drain();
    if (mismatch_count == 0 && waiting_count == 0) begin
      $display("[menu_run_timer_with_debounce] OK");
    end else begin
      $display("[menu_run_timer_with_debounce] ERROR");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("[menu_run_timer_with_debounce] ERROR");
    $finish;
  end

endmodule

/* files.f */
design/mtd_pkg.sv
design/mtd_cfg.sv
design/mtd_debounce.sv
design/mtd_ctrl.sv
design/menu_run_timer_with_debounce.sv
test/stopwatch_check.sv
test/tb_top.sv
